[rtl/asd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants of the archive stream deframer: parser phases,
// event and error codes, header bytes and the per-item result record.
// ----------------------------------------------------------------------------
package asd_pkg;

   localparam int unsigned NAME_LIMIT_W = 12;
   localparam int unsigned NAME_COUNT_W = 13;
   localparam int unsigned LEN_BYTES    = 8;

   localparam logic [NAME_LIMIT_W-1:0] NAME_LIMIT_RST = 12'd4095;

   // stream header bytes, in arrival order
   localparam logic [7:0] HDR_MAGIC [0:3] = '{8'h43, 8'h41, 8'h52, 8'h00};

   localparam logic [7:0] ATTR_FILE_BIT = 8'h20;
   localparam logic [7:0] ATTR_DIR_BIT  = 8'h40;
   localparam logic [7:0] ATTR_LINK_BIT = 8'h80;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_NAME    = 3'd1,
      PH_ATTR    = 3'd2,
      PH_LINK    = 3'd3,
      PH_LENGTH  = 3'd4,
      PH_DATA    = 3'd5,
      PH_STOPPED = 3'd6
   } phase_type;

   typedef enum logic [3:0] {
      EV_HEADER     = 4'd0,
      EV_NAME_BYTE  = 4'd1,
      EV_NAME_END   = 4'd2,
      EV_DIR        = 4'd3,
      EV_LINK_START = 4'd4,
      EV_LINK_BYTE  = 4'd5,
      EV_LINK_END   = 4'd6,
      EV_LEN_BYTE   = 4'd7,
      EV_FILE_START = 4'd8,
      EV_DATA       = 4'd9,
      EV_END        = 4'd10,
      EV_ERROR      = 4'd11,
      EV_STOPPED    = 4'd12
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_HEADER    = 3'd1,
      ERR_NAME_LONG = 3'd2,
      ERR_ATTR      = 3'd3,
      ERR_LINK_LONG = 3'd4
   } error_type;

   typedef struct packed {
      event_type   evt;
      logic [7:0]  byte_value;
      logic [8:0]  perm;
      logic [63:0] flen;
      logic        done;
      error_type   err;
   } result_type;

endpackage
`default_nettype wire

[rtl/archive_stream_deframer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// archive_stream_deframer_core
// Byte-wise deframer for an archive stream: header check, entry parsing and
// per-byte role reporting.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one archive byte per item (valid/ready).
//   rsp_*  : one result item per input byte: event, the byte itself,
//            permissions on attribute bytes, file length on file start,
//            file done flag and error code.
//   csr_*  : name_limit write channel, always ready; write only while idle.
// Path: an accepted byte is registered in the input register, processed into
//   the result register and offered on rsp_* until taken.
// Throughput: one item per cycle while rsp_ready stays high; the parse step
//   is a single pass from the input register into the result register.
// Stall: while rsp_ready is low the result holds and one more item can sit
//   in the input register; req_ready drops only when both are full.
// Reset: synchronous; both stages empty, parser back to header check,
//   name_limit back to 4095. After an error or the end item every later
//   byte reports the stopped event until reset.
// ----------------------------------------------------------------------------
module archive_stream_deframer_core #(
   parameter int unsigned MAX_PATH_BYTES = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_byte_in,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [3:0]                              rsp_event_res,
   output logic [7:0]                              rsp_byte_value,
   output logic [8:0]                              rsp_permissions,
   output logic [63:0]                             rsp_file_length,
   output logic                                    rsp_file_done,
   output logic [2:0]                              rsp_error_code,

   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [asd_pkg::NAME_LIMIT_W-1:0]   csr_name_limit
);

   logic                                in_valid_ff;
   logic [7:0]                          in_byte_ff;
   logic                                rsp_valid_ff;
   asd_pkg::result_type                 rsp_ff;
   logic [asd_pkg::NAME_LIMIT_W-1:0]    name_limit_ff;

   logic                                advance;
   logic                                step;
   logic                                req_fire;
   asd_pkg::result_type                 step_result;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         name_limit_ff <= asd_pkg::NAME_LIMIT_RST;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (csr_valid) begin
            name_limit_ff <= csr_name_limit;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_byte_in;
      end
      if (step) begin
         rsp_ff <= step_result;
      end
   end

   asd_parser #(
      .MAX_PATH_BYTES (MAX_PATH_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_in    (in_byte_ff),
      .name_limit (name_limit_ff),
      .result     (step_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_ff.evt;
   assign rsp_byte_value  = rsp_ff.byte_value;
   assign rsp_permissions = rsp_ff.perm;
   assign rsp_file_length = rsp_ff.flen;
   assign rsp_file_done   = rsp_ff.done;
   assign rsp_error_code  = rsp_ff.err;

   // error code present exactly on error items
   a_err_on_error : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_ff.evt == asd_pkg::EV_ERROR) == (rsp_ff.err != asd_pkg::ERR_NONE)))
      else $error("error code and error event disagree");

   a_done_on_file : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done) |->
         (rsp_ff.evt == asd_pkg::EV_FILE_START || rsp_ff.evt == asd_pkg::EV_DATA))
      else $error("file done outside file start or data");

   a_len_on_start : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.flen != 64'd0) |-> (rsp_ff.evt == asd_pkg::EV_FILE_START))
      else $error("file length outside file start");

   a_ready_low : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input blocked without both stages full");

endmodule
`default_nettype wire

[rtl/asd_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asd_parser
// Parse state of the deframer. Works out the result of one byte and the next
// parse state in one pass; the state moves on when step is high.
// ----------------------------------------------------------------------------
module asd_parser #(
   parameter int unsigned MAX_PATH_BYTES = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step,
   input  wire logic [7:0]                         byte_in,
   input  wire logic [asd_pkg::NAME_LIMIT_W-1:0]   name_limit,
   output asd_pkg::result_type                     result
);

   localparam int unsigned LINK_W = $clog2(MAX_PATH_BYTES + 1);
   localparam logic [LINK_W-1:0] LINK_MAX = LINK_W'(MAX_PATH_BYTES);

   asd_pkg::phase_type                  phase_ff, phase_in;
   logic [1:0]                          hdr_count_ff, hdr_count_in;
   logic                                hdr_bad_ff, hdr_bad_in;
   logic [asd_pkg::NAME_COUNT_W-1:0]    name_count_ff, name_count_in;
   logic [LINK_W-1:0]                   link_count_ff, link_count_in;
   logic [2:0]                          len_count_ff, len_count_in;
   logic [63:0]                         remaining_ff, remaining_in;

   logic [asd_pkg::NAME_COUNT_W-1:0]    name_inc;
   logic [LINK_W-1:0]                   link_inc;
   logic [63:0]                         len_full;
   logic                                hdr_miss;

   assign name_inc = name_count_ff + asd_pkg::NAME_COUNT_W'(1);
   assign link_inc = link_count_ff + LINK_W'(1);
   // length as it stands once the eighth byte lands
   assign len_full = {byte_in, remaining_ff[55:0]};
   assign hdr_miss = (byte_in != asd_pkg::HDR_MAGIC[hdr_count_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= asd_pkg::PH_HEADER;
         hdr_count_ff  <= '0;
         hdr_bad_ff    <= 1'b0;
         name_count_ff <= '0;
         link_count_ff <= '0;
         len_count_ff  <= '0;
         remaining_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         hdr_count_ff  <= hdr_count_in;
         hdr_bad_ff    <= hdr_bad_in;
         name_count_ff <= name_count_in;
         link_count_ff <= link_count_in;
         len_count_ff  <= len_count_in;
         remaining_ff  <= remaining_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      hdr_count_in  = hdr_count_ff;
      hdr_bad_in    = hdr_bad_ff;
      name_count_in = name_count_ff;
      link_count_in = link_count_ff;
      len_count_in  = len_count_ff;
      remaining_in  = remaining_ff;

      result.evt        = asd_pkg::EV_STOPPED;
      result.byte_value = byte_in;
      result.perm       = '0;
      result.flen       = '0;
      result.done       = 1'b0;
      result.err        = asd_pkg::ERR_NONE;

      case (phase_ff)
         asd_pkg::PH_HEADER: begin
            hdr_bad_in   = hdr_bad_ff | hdr_miss;
            hdr_count_in = hdr_count_ff + 2'd1;
            result.evt   = asd_pkg::EV_HEADER;
            if (hdr_count_ff == 2'd3) begin
               if (hdr_bad_ff || hdr_miss) begin
                  result.evt = asd_pkg::EV_ERROR;
                  result.err = asd_pkg::ERR_HEADER;
                  phase_in   = asd_pkg::PH_STOPPED;
               end else begin
                  name_count_in = '0;
                  phase_in      = asd_pkg::PH_NAME;
               end
            end
         end
         asd_pkg::PH_NAME: begin
            name_count_in = name_inc;
            if (byte_in == 8'h00) begin
               // a lone null as name closes the archive
               if (name_inc == asd_pkg::NAME_COUNT_W'(1)) begin
                  result.evt = asd_pkg::EV_END;
                  phase_in   = asd_pkg::PH_STOPPED;
               end else begin
                  result.evt = asd_pkg::EV_NAME_END;
                  phase_in   = asd_pkg::PH_ATTR;
               end
            end else if (name_inc >= {1'b0, name_limit}) begin
               result.evt = asd_pkg::EV_ERROR;
               result.err = asd_pkg::ERR_NAME_LONG;
               phase_in   = asd_pkg::PH_STOPPED;
            end else begin
               result.evt = asd_pkg::EV_NAME_BYTE;
            end
         end
         asd_pkg::PH_ATTR: begin
            result.perm = {byte_in[2:0], byte_in[2:0], byte_in[2:0]};
            if ((byte_in & asd_pkg::ATTR_DIR_BIT) != 8'h00) begin
               result.evt    = asd_pkg::EV_DIR;
               name_count_in = '0;
               phase_in      = asd_pkg::PH_NAME;
            end else if ((byte_in & asd_pkg::ATTR_LINK_BIT) != 8'h00) begin
               result.evt    = asd_pkg::EV_LINK_START;
               link_count_in = '0;
               phase_in      = asd_pkg::PH_LINK;
            end else if ((byte_in & asd_pkg::ATTR_FILE_BIT) != 8'h00) begin
               result.evt   = asd_pkg::EV_LEN_BYTE;
               len_count_in = '0;
               remaining_in = '0;
               phase_in     = asd_pkg::PH_LENGTH;
            end else begin
               result.evt = asd_pkg::EV_ERROR;
               result.err = asd_pkg::ERR_ATTR;
               phase_in   = asd_pkg::PH_STOPPED;
            end
         end
         asd_pkg::PH_LINK: begin
            link_count_in = link_inc;
            if (byte_in == 8'h00) begin
               result.evt    = asd_pkg::EV_LINK_END;
               name_count_in = '0;
               phase_in      = asd_pkg::PH_NAME;
            end else if (link_inc >= LINK_MAX) begin
               result.evt = asd_pkg::EV_ERROR;
               result.err = asd_pkg::ERR_LINK_LONG;
               phase_in   = asd_pkg::PH_STOPPED;
            end else begin
               result.evt = asd_pkg::EV_LINK_BYTE;
            end
         end
         asd_pkg::PH_LENGTH: begin
            // little-endian: byte lane picked by the length count
            for (int i = 0; i < asd_pkg::LEN_BYTES; i++) begin
               if (len_count_ff == 3'(i)) begin
                  remaining_in[8*i +: 8] = byte_in;
               end
            end
            len_count_in = len_count_ff + 3'd1;
            result.evt   = asd_pkg::EV_LEN_BYTE;
            if (len_count_ff == 3'd7) begin
               result.evt  = asd_pkg::EV_FILE_START;
               result.flen = len_full;
               if (len_full == 64'd0) begin
                  result.done   = 1'b1;
                  name_count_in = '0;
                  phase_in      = asd_pkg::PH_NAME;
               end else begin
                  phase_in = asd_pkg::PH_DATA;
               end
            end
         end
         asd_pkg::PH_DATA: begin
            result.evt   = asd_pkg::EV_DATA;
            remaining_in = remaining_ff - 64'd1;
            if (remaining_ff <= 64'd1) begin
               result.done   = 1'b1;
               name_count_in = '0;
               phase_in      = asd_pkg::PH_NAME;
            end
         end
         asd_pkg::PH_STOPPED: begin
            result.evt = asd_pkg::EV_STOPPED;
         end
         default: begin
            result.evt = asd_pkg::EV_STOPPED;
            phase_in   = asd_pkg::PH_STOPPED;
         end
      endcase
   end

endmodule
`default_nettype wire

[tb/archive_stream_deframer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// archive_stream_deframer_core_tb
// Self-checking bench for the archive stream deframer. One archive stream is
// fed per run: a short scripted opening, then random entries under several
// name limits, then one randomly chosen way of closing the stream. Every
// result item is checked field by field against a scripted value or the model.
// ----------------------------------------------------------------------------
module archive_stream_deframer_core_tb;

   localparam int unsigned LINK_TARGET_MAX = 4096;
   localparam int unsigned CYCLE_LIMIT     = 1000000;
   localparam int unsigned HOLD_CYCLES     = 300;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_PATTERN,
      STALL_RARE
   } stall_mode_type;

   typedef enum logic [2:0] {
      FIN_END_MARK,
      FIN_NAME_LONG,
      FIN_BAD_ATTR,
      FIN_LINK_LONG,
      FIN_OPEN_FILE,
      FIN_BAD_HEADER
   } finish_kind_type;

   typedef struct packed {
      logic [7:0]          data;
      logic                typed;
      asd_pkg::result_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_byte_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_event_res;
   logic [7:0]  rsp_byte_value;
   logic [8:0]  rsp_permissions;
   logic [63:0] rsp_file_length;
   logic        rsp_file_done;
   logic [2:0]  rsp_error_code;
   logic        csr_valid;
   logic        csr_ready;
   logic [asd_pkg::NAME_LIMIT_W-1:0] csr_name_limit;

   // parser model state, at its reset values
   asd_pkg::phase_type               parse_phase = asd_pkg::PH_HEADER;
   logic [2:0]                       hdr_count   = '0;
   logic                             hdr_bad     = 1'b0;
   logic [asd_pkg::NAME_COUNT_W-1:0] name_count  = '0;
   int unsigned                      link_count  = 0;
   logic [3:0]                       len_count   = '0;
   logic [63:0]                      file_left   = '0;
   logic [asd_pkg::NAME_LIMIT_W-1:0] limit_reg   = asd_pkg::NAME_LIMIT_RST;

   asd_pkg::result_type reports_due [$];
   script_row_type      directed_rows [$];
   asd_pkg::result_type head_report;
   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count    = 0;
   int unsigned    bytes_sent     = 0;
   int             burst_left     = 0;
   logic           hold_off_req   = 1'b0;
   finish_kind_type finish_kind;

   archive_stream_deframer_core #(
      .MAX_PATH_BYTES (LINK_TARGET_MAX)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_permissions (rsp_permissions),
      .rsp_file_length (rsp_file_length),
      .rsp_file_done   (rsp_file_done),
      .rsp_error_code  (rsp_error_code),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_name_limit  (csr_name_limit)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // advances the parser model by one byte and returns the report for it
   function automatic asd_pkg::result_type parse_byte(input logic [7:0] b);
      asd_pkg::result_type r;
      r            = '0;
      r.byte_value = b;
      r.evt        = asd_pkg::EV_STOPPED;
      r.err        = asd_pkg::ERR_NONE;
      case (parse_phase)
         asd_pkg::PH_HEADER: begin
            if (b != asd_pkg::HDR_MAGIC[hdr_count[1:0]]) hdr_bad = 1'b1;
            hdr_count = hdr_count + 3'd1;
            r.evt     = asd_pkg::EV_HEADER;
            if (hdr_count >= 3'd4) begin
               if (hdr_bad) begin
                  r.evt       = asd_pkg::EV_ERROR;
                  r.err       = asd_pkg::ERR_HEADER;
                  parse_phase = asd_pkg::PH_STOPPED;
               end else begin
                  name_count  = '0;
                  parse_phase = asd_pkg::PH_NAME;
               end
            end
         end
         asd_pkg::PH_NAME: begin
            if (name_count != '1) name_count = name_count + 1'b1;
            if (b == 8'h00) begin
               // a lone terminator is the end-of-archive marker
               if (name_count == 1) begin
                  r.evt       = asd_pkg::EV_END;
                  parse_phase = asd_pkg::PH_STOPPED;
               end else begin
                  r.evt       = asd_pkg::EV_NAME_END;
                  parse_phase = asd_pkg::PH_ATTR;
               end
            end else if (name_count >= {1'b0, limit_reg}) begin
               r.evt       = asd_pkg::EV_ERROR;
               r.err       = asd_pkg::ERR_NAME_LONG;
               parse_phase = asd_pkg::PH_STOPPED;
            end else begin
               r.evt = asd_pkg::EV_NAME_BYTE;
            end
         end
         asd_pkg::PH_ATTR: begin
            r.perm = {b[2:0], b[2:0], b[2:0]};
            if ((b & asd_pkg::ATTR_DIR_BIT) != 8'h00) begin
               r.evt       = asd_pkg::EV_DIR;
               name_count  = '0;
               parse_phase = asd_pkg::PH_NAME;
            end else if ((b & asd_pkg::ATTR_LINK_BIT) != 8'h00) begin
               r.evt       = asd_pkg::EV_LINK_START;
               link_count  = 0;
               parse_phase = asd_pkg::PH_LINK;
            end else if ((b & asd_pkg::ATTR_FILE_BIT) != 8'h00) begin
               r.evt       = asd_pkg::EV_LEN_BYTE;
               len_count   = '0;
               file_left   = '0;
               parse_phase = asd_pkg::PH_LENGTH;
            end else begin
               r.evt       = asd_pkg::EV_ERROR;
               r.err       = asd_pkg::ERR_ATTR;
               parse_phase = asd_pkg::PH_STOPPED;
            end
         end
         asd_pkg::PH_LINK: begin
            if (link_count < 32'hFFFFF) link_count++;
            if (b == 8'h00) begin
               r.evt       = asd_pkg::EV_LINK_END;
               name_count  = '0;
               parse_phase = asd_pkg::PH_NAME;
            end else if (link_count >= LINK_TARGET_MAX) begin
               r.evt       = asd_pkg::EV_ERROR;
               r.err       = asd_pkg::ERR_LINK_LONG;
               parse_phase = asd_pkg::PH_STOPPED;
            end else begin
               r.evt = asd_pkg::EV_LINK_BYTE;
            end
         end
         asd_pkg::PH_LENGTH: begin
            file_left = file_left | (64'(b) << (8 * len_count[2:0]));
            len_count = len_count + 4'd1;
            r.evt     = asd_pkg::EV_LEN_BYTE;
            if (len_count >= 4'(asd_pkg::LEN_BYTES)) begin
               r.evt  = asd_pkg::EV_FILE_START;
               r.flen = file_left;
               if (file_left == '0) begin
                  r.done      = 1'b1;
                  name_count  = '0;
                  parse_phase = asd_pkg::PH_NAME;
               end else begin
                  parse_phase = asd_pkg::PH_DATA;
               end
            end
         end
         asd_pkg::PH_DATA: begin
            r.evt = asd_pkg::EV_DATA;
            if (file_left != '0) file_left = file_left - 64'd1;
            if (file_left == '0) begin
               r.done      = 1'b1;
               name_count  = '0;
               parse_phase = asd_pkg::PH_NAME;
            end
         end
         default: begin
            r.evt       = asd_pkg::EV_STOPPED;
            parse_phase = asd_pkg::PH_STOPPED;
         end
      endcase
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                            input asd_pkg::result_type known = '0);
      asd_pkg::result_type calc;
      if (burst_left <= 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 20);
      end
      req_byte_in = b;
      req_valid   = 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      calc = parse_byte(b);
      reports_due.push_back(typed ? known : calc);
      bytes_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic write_name_limit(input logic [asd_pkg::NAME_LIMIT_W-1:0] value);
      req_valid = 1'b0;
      while (reports_due.size() != 0) @(negedge clock);
      csr_name_limit = value;
      csr_valid      = 1'b1;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      limit_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_name(input int unsigned len);
      repeat (len) push_byte(8'($urandom_range(1, 255)));
      push_byte(8'h00);
   endtask

   task automatic add_known_row(input logic [7:0] data, input asd_pkg::event_type evt,
                                input logic [8:0] perm, input logic [63:0] flen,
                                input logic done);
      script_row_type row;
      row.data            = data;
      row.typed           = 1'b1;
      row.want.evt        = evt;
      row.want.byte_value = data;
      row.want.perm       = perm;
      row.want.flen       = flen;
      row.want.done       = done;
      row.want.err        = asd_pkg::ERR_NONE;
      directed_rows.push_back(row);
   endtask

   task automatic add_free_row(input logic [7:0] data);
      script_row_type row;
      row       = '0;
      row.data  = data;
      directed_rows.push_back(row);
   endtask

   // well-formed entries with random content until the byte budget is spent
   task automatic send_entries(input int unsigned budget);
      int unsigned start_count;
      int unsigned name_cap;
      int unsigned name_len;
      int unsigned kind_pick;
      logic [63:0] flen;
      start_count = bytes_sent;
      while (bytes_sent - start_count < budget) begin
         name_cap = (limit_reg - 1 > 12) ? 12 : limit_reg - 1;
         name_len = $urandom_range(1, name_cap);
         if (limit_reg - 1 <= 64 && $urandom_range(0, 4) == 0) name_len = limit_reg - 1;
         send_name(name_len);
         kind_pick = $urandom_range(0, 9);
         if (kind_pick < 3) begin
            push_byte(8'($urandom_range(0, 255)) | asd_pkg::ATTR_DIR_BIT);
         end else if (kind_pick < 6) begin
            push_byte((8'($urandom_range(0, 255)) | asd_pkg::ATTR_LINK_BIT)
                      & ~asd_pkg::ATTR_DIR_BIT);
            repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(1, 255)));
            push_byte(8'h00);
         end else begin
            push_byte((8'($urandom_range(0, 255)) | asd_pkg::ATTR_FILE_BIT)
                      & ~(asd_pkg::ATTR_DIR_BIT | asd_pkg::ATTR_LINK_BIT));
            case ($urandom_range(0, 9))
               0, 1, 2: flen = '0;
               9:       flen = 64'($urandom_range(200, 300));
               default: flen = 64'($urandom_range(1, 12));
            endcase
            for (int i = 0; i < asd_pkg::LEN_BYTES; i++) push_byte(flen[8*i +: 8]);
            repeat (int'(flen)) push_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // receiver: changing stall patterns, plus one long hold-off on request
   initial begin
      stall_mode_type stall_mode;
      int unsigned    mode_left;
      int unsigned    tick;
      stall_mode = STALL_NONE;
      mode_left  = 0;
      tick       = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (stall_mode)
               STALL_NONE:    rsp_ready = 1'b1;
               STALL_COIN:    rsp_ready = ($urandom_range(0, 1) == 1);
               STALL_PATTERN: rsp_ready = ((tick % 5) < 3);
               default:       rsp_ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic note_mismatch(input string field, input logic [63:0] want_v,
                                input logic [63:0] got_v);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v,
               got_v);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (reports_due.size() == 0) begin
            $display("%0t: result item with none expected, event %0d byte 0x%0h", $time,
                     rsp_event_res, rsp_byte_value);
            mismatch_count++;
         end else begin
            head_report = reports_due.pop_front();
            if (rsp_event_res !== head_report.evt)
               note_mismatch("event", head_report.evt, rsp_event_res);
            if (rsp_byte_value !== head_report.byte_value)
               note_mismatch("byte", head_report.byte_value, rsp_byte_value);
            if (rsp_permissions !== head_report.perm)
               note_mismatch("permissions", head_report.perm, rsp_permissions);
            if (rsp_file_length !== head_report.flen)
               note_mismatch("file length", head_report.flen, rsp_file_length);
            if (rsp_file_done !== head_report.done)
               note_mismatch("file done", head_report.done, rsp_file_done);
            if (rsp_error_code !== head_report.err)
               note_mismatch("error code", head_report.err, rsp_error_code);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time, reports_due.size());
         $display("archive_stream_deframer_core regression: fail");
         $finish;
      end
   end

   initial begin
      logic [7:0]  hdr [4];
      logic [63:0] huge_len;
      int unsigned bad_idx;
      int unsigned entry_budget;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_byte_in    = '0;
      csr_valid      = 1'b0;
      csr_name_limit = '0;
      // only one reset per run, so only one way of closing the stream
      finish_kind = ($urandom_range(0, 9) == 0) ? FIN_BAD_HEADER
                                                : finish_kind_type'($urandom_range(0, 4));
      // an over-long link target is itself a few thousand items
      entry_budget = (finish_kind == FIN_LINK_LONG) ? 100 : 600;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      write_name_limit(asd_pkg::NAME_LIMIT_RST);

      if (finish_kind == FIN_BAD_HEADER) begin
         for (int i = 0; i < 4; i++) hdr[i] = asd_pkg::HDR_MAGIC[i];
         bad_idx      = $urandom_range(0, 3);
         hdr[bad_idx] = hdr[bad_idx] ^ 8'($urandom_range(1, 255));
         for (int i = 0; i < 4; i++) push_byte(hdr[i]);
      end else begin
         for (int i = 0; i < 4; i++)
            add_known_row(asd_pkg::HDR_MAGIC[i], asd_pkg::EV_HEADER, '0, '0, 1'b0);
         // directory bit wins over link and file
         add_free_row(8'hFF);
         add_free_row(8'h00);
         add_known_row(8'hE7, asd_pkg::EV_DIR, 9'h1FF, '0, 1'b0);
         // link wins over file; one-byte target
         add_free_row(8'h01);
         add_free_row(8'h00);
         add_free_row(8'hA0);
         add_free_row(8'h7F);
         add_free_row(8'h00);
         // zero-length file completes on its last length byte
         add_free_row(8'h20);
         add_free_row(8'h00);
         add_free_row(8'h25);
         repeat (asd_pkg::LEN_BYTES - 1) add_free_row(8'h00);
         add_known_row(8'h00, asd_pkg::EV_FILE_START, '0, '0, 1'b1);
         foreach (directed_rows[i])
            push_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
      end

      write_name_limit(12'($urandom_range(2, 6)));
      send_entries(entry_budget / 2);

      write_name_limit(12'($urandom_range(7, 4094)));
      hold_off_req = 1'b1;
      send_entries(entry_budget);

      // longest name the limit allows
      write_name_limit(12'($urandom_range(100, 300)));
      send_name(limit_reg - 1);
      push_byte(asd_pkg::ATTR_DIR_BIT);
      send_entries(entry_budget);

      case (finish_kind)
         FIN_END_MARK: begin
            write_name_limit(12'd1);
            push_byte(8'h00);
         end
         FIN_NAME_LONG: begin
            write_name_limit(12'($urandom_range(0, 5)));
            repeat (8) push_byte(8'($urandom_range(1, 255)));
         end
         FIN_BAD_ATTR: begin
            write_name_limit(12'($urandom_range(2, 4095)));
            send_name($urandom_range(1, 4));
            push_byte(8'($urandom_range(0, 255))
                      & ~(asd_pkg::ATTR_DIR_BIT | asd_pkg::ATTR_LINK_BIT
                          | asd_pkg::ATTR_FILE_BIT));
         end
         FIN_LINK_LONG: begin
            write_name_limit(12'($urandom_range(2, 4095)));
            send_name(2);
            push_byte(asd_pkg::ATTR_LINK_BIT | 8'($urandom_range(0, 7)));
            repeat (LINK_TARGET_MAX) push_byte(8'($urandom_range(1, 255)));
         end
         FIN_OPEN_FILE: begin
            write_name_limit(12'($urandom_range(2, 4095)));
            send_name(3);
            push_byte(asd_pkg::ATTR_FILE_BIT | 8'($urandom_range(0, 7)));
            huge_len = ($urandom_range(0, 1) == 1) ? '1 : ({$urandom, $urandom} | 64'h1);
            for (int i = 0; i < asd_pkg::LEN_BYTES; i++) push_byte(huge_len[8*i +: 8]);
            repeat (150) push_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            write_name_limit(12'($urandom_range(1, 4095)));
         end
      endcase
      repeat (30) push_byte(8'($urandom_range(0, 255)));

      req_valid = 1'b0;
      while (reports_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("archive_stream_deframer_core regression: pass");
      else
         $display("archive_stream_deframer_core regression: fail");
      $finish;
   end

endmodule

[sim.f]
rtl/asd_pkg.sv
rtl/asd_parser.sv
rtl/archive_stream_deframer_core.sv
tb/archive_stream_deframer_core_tb.sv
